// File: rtl/assf_pkg.sv
// ----------------------------------------------------------------------------
// assf_pkg: shared types and constants of the seven-segment formatter
// Widths, decimal split constants, pipeline payload types and the
// segment code table.
// ----------------------------------------------------------------------------
package assf_pkg;

    localparam int VALUE_W    = 24;
    localparam int SHOWN_W    = 14;
    localparam int HALF_W     = 7;
    localparam int DIGIT_W    = 4;
    localparam int SEG_W      = 8;
    localparam int NUM_DIGITS = 4;
    localparam int POS_W      = 2;

    // largest value the display can show
    localparam logic [SHOWN_W-1:0] SAT_LIMIT = 14'd9999;

    // decimal point in the segment word
    localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;

    // x / 100 as (x * 5243) >> 19, exact for x <= 9999
    localparam logic [12:0] RECIP100       = 13'd5243;
    localparam int          RECIP100_SHIFT = 19;

    // x / 10 as (x * 103) >> 10, exact for x <= 99
    localparam logic [6:0]  RECIP10        = 7'd103;
    localparam int          RECIP10_SHIFT  = 10;

    // scaled display value with its point mask (bit k lights position k)
    typedef struct packed {
        logic [SHOWN_W-1:0]    shown;
        logic [NUM_DIGITS-1:0] point;
    } scaled_t;

    // value split into two halves of two digits each
    typedef struct packed {
        logic [HALF_W-1:0]     hi;
        logic [HALF_W-1:0]     lo;
        logic [DIGIT_W-1:0]    hi_tens;
        logic [DIGIT_W-1:0]    lo_tens;
        logic [NUM_DIGITS-1:0] point;
    } split_t;

    // segments a-g on bits 0-6, lit high
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h3f;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5b;
            4'd3:    code = 8'h4f;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6d;
            4'd6:    code = 8'h7d;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7f;
            4'd9:    code = 8'h6f;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/assf_scale.sv
// ----------------------------------------------------------------------------
// assf_scale: range selection and scaling
// Stage A picks the display range of the fixed-point value, stage B
// multiplies by the range scale and drops the fraction bits.
// ----------------------------------------------------------------------------
module assf_scale #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [assf_pkg::VALUE_W-1:0]      in_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output assf_pkg::scaled_t                 out_data
);

    localparam int VW     = assf_pkg::VALUE_W;
    localparam int PROD_W = VW + 10;
    localparam logic [VW-1:0] FRAC_MASK = VW'((1 << FRACTION_BITS) - 1);

    typedef enum logic [1:0] {
        RNG_UNITS,
        RNG_TENS,
        RNG_HUNDREDS,
        RNG_WHOLE
    } range_t;

    logic               a_vld_reg;
    logic [VW-1:0]      a_value_reg;
    range_t             a_range_reg;
    logic               a_sat_reg;
    logic               b_vld_reg;
    assf_pkg::scaled_t  b_data_reg;

    logic               a_ready;
    logic               b_ready;
    logic [VW-1:0]      int_part;
    logic               frac_nz;
    range_t             a_range_next;
    logic               a_sat_next;
    logic [9:0]         scale;
    logic [PROD_W-1:0]  product;
    assf_pkg::scaled_t  b_data_next;

    assign b_ready  = !b_vld_reg || out_ready;
    assign a_ready  = !a_vld_reg || b_ready;
    assign in_ready = a_ready;

    // classify the integer part
    always_comb begin
        int_part   = in_value >> FRACTION_BITS;
        frac_nz    = |(in_value & FRAC_MASK);
        a_sat_next = (int_part > VW'(assf_pkg::SAT_LIMIT)) ||
                     ((int_part == VW'(assf_pkg::SAT_LIMIT)) && frac_nz);
        if (int_part < VW'(10)) begin
            a_range_next = RNG_UNITS;
        end else if (int_part < VW'(100)) begin
            a_range_next = RNG_TENS;
        end else if (int_part < VW'(1000)) begin
            a_range_next = RNG_HUNDREDS;
        end else begin
            a_range_next = RNG_WHOLE;
        end
    end

    // scale, truncate and place the point
    always_comb begin
        case (a_range_reg)
            RNG_UNITS: begin
                scale             = 10'd1000;
                b_data_next.point = 4'b1000;
            end
            RNG_TENS: begin
                scale             = 10'd100;
                b_data_next.point = 4'b0100;
            end
            RNG_HUNDREDS: begin
                scale             = 10'd10;
                b_data_next.point = 4'b0010;
            end
            default: begin
                scale             = 10'd1;
                b_data_next.point = 4'b0000;
            end
        endcase
        product           = PROD_W'(a_value_reg) * PROD_W'(scale);
        b_data_next.shown = product[FRACTION_BITS +: assf_pkg::SHOWN_W];
        if (a_sat_reg) begin
            b_data_next.shown = assf_pkg::SAT_LIMIT;
            b_data_next.point = '0;
        end
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_vld_reg <= in_valid;
            end
            if (b_ready) begin
                b_vld_reg <= a_vld_reg;
            end
        end
    end

    // hold payload until the stage moves
    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_value_reg <= in_value;
            a_range_reg <= a_range_next;
            a_sat_reg   <= a_sat_next;
        end
        if (b_ready && a_vld_reg) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_vld_reg;
    assign out_data  = b_data_reg;

`ifndef ASSERT_OFF
    // displayed value never exceeds four digits
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_vld_reg |-> b_data_reg.shown <= assf_pkg::SAT_LIMIT)
        else $error("scaled value out of display range");

    // at most one point lit
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_vld_reg |-> $onehot0(b_data_reg.point))
        else $error("more than one decimal point");

    // a stalled stage keeps its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_vld_reg && !out_ready) |=> b_vld_reg && $stable(b_data_reg))
        else $error("scaled word lost under stall");
`endif

endmodule

// File: rtl/assf_split.sv
// ----------------------------------------------------------------------------
// assf_split: decimal split
// Stage C divides by 100, stage D forms the low half, stage E divides both
// halves by 10, giving the tens digits of each half.
// ----------------------------------------------------------------------------
module assf_split (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  assf_pkg::scaled_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output assf_pkg::split_t   out_data
);

    localparam int SW = assf_pkg::SHOWN_W;
    localparam int HW = assf_pkg::HALF_W;
    localparam int ND = assf_pkg::NUM_DIGITS;

    logic               c_vld_reg;
    logic [SW-1:0]      c_shown_reg;
    logic [HW-1:0]      c_hi_reg;
    logic [ND-1:0]      c_point_reg;
    logic               d_vld_reg;
    logic [HW-1:0]      d_hi_reg;
    logic [HW-1:0]      d_lo_reg;
    logic [ND-1:0]      d_point_reg;
    logic               e_vld_reg;
    assf_pkg::split_t   e_data_reg;

    logic               c_ready;
    logic               d_ready;
    logic               e_ready;
    logic [27:0]        prod_c;
    logic [HW-1:0]      c_hi_next;
    logic [SW-1:0]      times100;
    logic [SW-1:0]      lo_full;
    logic [HW-1:0]      d_lo_next;
    logic [13:0]        prod_hi;
    logic [13:0]        prod_lo;
    assf_pkg::split_t   e_data_next;

    assign e_ready  = !e_vld_reg || out_ready;
    assign d_ready  = !d_vld_reg || e_ready;
    assign c_ready  = !c_vld_reg || d_ready;
    assign in_ready = c_ready;

    // divide by 100 through the reciprocal
    always_comb begin
        prod_c    = 28'(in_data.shown) * 28'(assf_pkg::RECIP100);
        c_hi_next = prod_c[assf_pkg::RECIP100_SHIFT +: HW];
    end

    // remainder of the divide by 100
    always_comb begin
        times100  = SW'({c_hi_reg, 6'b0}) + SW'({c_hi_reg, 5'b0}) + SW'({c_hi_reg, 2'b0});
        lo_full   = c_shown_reg - times100;
        d_lo_next = lo_full[HW-1:0];
    end

    // tens digit of each half
    always_comb begin
        prod_hi             = 14'(d_hi_reg) * 14'(assf_pkg::RECIP10);
        prod_lo             = 14'(d_lo_reg) * 14'(assf_pkg::RECIP10);
        e_data_next.hi      = d_hi_reg;
        e_data_next.lo      = d_lo_reg;
        e_data_next.hi_tens = prod_hi[assf_pkg::RECIP10_SHIFT +: assf_pkg::DIGIT_W];
        e_data_next.lo_tens = prod_lo[assf_pkg::RECIP10_SHIFT +: assf_pkg::DIGIT_W];
        e_data_next.point   = d_point_reg;
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end else begin
            if (c_ready) begin
                c_vld_reg <= in_valid;
            end
            if (d_ready) begin
                d_vld_reg <= c_vld_reg;
            end
            if (e_ready) begin
                e_vld_reg <= d_vld_reg;
            end
        end
    end

    // hold payload until the stage moves
    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            c_shown_reg <= in_data.shown;
            c_hi_reg    <= c_hi_next;
            c_point_reg <= in_data.point;
        end
        if (d_ready && c_vld_reg) begin
            d_hi_reg    <= c_hi_reg;
            d_lo_reg    <= d_lo_next;
            d_point_reg <= c_point_reg;
        end
        if (e_ready && d_vld_reg) begin
            e_data_reg <= e_data_next;
        end
    end

    assign out_valid = e_vld_reg;
    assign out_data  = e_data_reg;

`ifndef ASSERT_OFF
    // both halves stay below 100
    assert property (@(posedge aclk) disable iff (!aresetn)
        d_vld_reg |-> (d_hi_reg <= HW'(99)) && (d_lo_reg <= HW'(99)))
        else $error("decimal half out of range");

    // tens digits are decimal
    assert property (@(posedge aclk) disable iff (!aresetn)
        e_vld_reg |-> (e_data_reg.hi_tens <= 4'd9) && (e_data_reg.lo_tens <= 4'd9))
        else $error("tens digit out of range");

    // a filled stage with a free successor hands its word on
    assert property (@(posedge aclk) disable iff (!aresetn)
        (d_vld_reg && e_ready) |=> e_vld_reg)
        else $error("word dropped between split stages");
`endif

endmodule

// File: rtl/assf_serial.sv
// ----------------------------------------------------------------------------
// assf_serial: digit serializer
// Forms the ones digits and segment words on load, then shifts out one digit
// word per cycle while out_ready is high, least significant position first.
// ----------------------------------------------------------------------------
module assf_serial (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  assf_pkg::split_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [assf_pkg::POS_W-1:0]           out_position,
    output logic [assf_pkg::SEG_W-1:0]           out_segments,
    output logic [assf_pkg::NUM_DIGITS-1:0]      out_enable_n,
    output logic                                 out_last
);

    localparam int ND = assf_pkg::NUM_DIGITS;
    localparam int PW = assf_pkg::POS_W;
    localparam int DW = assf_pkg::DIGIT_W;
    localparam int GW = assf_pkg::SEG_W;
    localparam int HW = assf_pkg::HALF_W;
    localparam logic [PW-1:0] LAST_POS = PW'(ND - 1);

    logic                   vld_reg;
    logic [PW-1:0]          pos_reg;
    logic [ND-1:0][GW-1:0]  seg_reg;

    logic                   at_last;
    logic                   in_fire;
    logic                   out_fire;
    logic [HW-1:0]          hi_ones_full;
    logic [HW-1:0]          lo_ones_full;
    logic [ND-1:0][DW-1:0]  digits;
    logic [ND-1:0][GW-1:0]  seg_next;

    assign at_last  = (pos_reg == LAST_POS);
    assign out_fire = vld_reg && out_ready;
    assign in_ready = !vld_reg || (out_ready && at_last);
    assign in_fire  = in_valid && in_ready;

    // ones digits and segment words
    always_comb begin
        hi_ones_full = in_data.hi - (HW'({in_data.hi_tens, 3'b0}) + HW'({in_data.hi_tens, 1'b0}));
        lo_ones_full = in_data.lo - (HW'({in_data.lo_tens, 3'b0}) + HW'({in_data.lo_tens, 1'b0}));
        digits[0]    = lo_ones_full[DW-1:0];
        digits[1]    = in_data.lo_tens;
        digits[2]    = hi_ones_full[DW-1:0];
        digits[3]    = in_data.hi_tens;
        for (int k = 0; k < ND; k++) begin
            seg_next[k] = assf_pkg::seg_code(digits[k]) |
                          (in_data.point[k] ? assf_pkg::POINT_BIT : '0);
        end
    end

    // load a new run or advance through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            pos_reg <= '0;
        end else if (in_fire) begin
            vld_reg <= 1'b1;
            pos_reg <= '0;
        end else if (out_fire) begin
            if (at_last) begin
                vld_reg <= 1'b0;
                pos_reg <= '0;
            end else begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    // shift segment words toward the output slot
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            seg_reg <= seg_next;
        end else if (out_fire) begin
            for (int k = 0; k < ND - 1; k++) begin
                seg_reg[k] <= seg_reg[k + 1];
            end
            seg_reg[ND-1] <= '0;
        end
    end

    assign out_valid    = vld_reg;
    assign out_position = pos_reg;
    assign out_segments = seg_reg[0];
    assign out_enable_n = ~(ND'(1) << pos_reg);
    assign out_last     = at_last;

`ifndef ASSERT_OFF
    // a taken digit word that is not the last moves to the next position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && !at_last) |=> vld_reg && (pos_reg == $past(pos_reg) + 1'b1))
        else $error("digit position did not advance");

    // an idle serializer rests at position zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg |-> pos_reg == '0)
        else $error("idle serializer off position zero");

    // a new run starts only at the end of the previous one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg && !at_last && in_valid) |-> !in_ready)
        else $error("run cut short by a new word");
`endif

endmodule

// File: rtl/autorange_seven_segment_formatter.sv
// ----------------------------------------------------------------------------
// autorange_seven_segment_formatter: four-digit auto-ranging display driver
// Turns an unsigned fixed-point value into four seven-segment digit words
// with the decimal point placed by range, saturating at 9999.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------------
//   s_      | in  | s_valid / s_ready  | s_value[23:0]
//   m_      | out | m_valid / m_ready  | m_digit_position, m_segments,
//           |     |                    | m_digit_enable_n, m_last
//
// Each value yields four words, one per cycle while m_ready is high; the
// serializer that emits them sets the sustained rate and takes no new value
// until the last word leaves. A value passes two scaling, three split and one
// serializer stage before its first word; five more can queue in the stages.
// Reset clears only the valid bits and the digit position.
// With m_ready low every stage holds its word; back-pressure passes through
// full stages at once; a stage takes a new word when empty or its word moves on.
// ----------------------------------------------------------------------------
module autorange_seven_segment_formatter #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [assf_pkg::VALUE_W-1:0]         s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [assf_pkg::POS_W-1:0]           m_digit_position,
    output logic [assf_pkg::SEG_W-1:0]           m_segments,
    output logic [assf_pkg::NUM_DIGITS-1:0]      m_digit_enable_n,
    output logic                                 m_last
);

    logic               scale_valid;
    logic               scale_ready;
    assf_pkg::scaled_t  scale_data;
    logic               split_valid;
    logic               split_ready;
    assf_pkg::split_t   split_data;

    // pick range and scale
    assf_scale #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale_data)
    );

    // split into decimal halves and tens digits
    assf_split u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scale_data),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .out_data  (split_data)
    );

    // emit digit words
    assf_serial u_serial (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (split_valid),
        .in_ready     (split_ready),
        .in_data      (split_data),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_position (m_digit_position),
        .out_segments (m_segments),
        .out_enable_n (m_digit_enable_n),
        .out_last     (m_last)
    );

endmodule
